[rtl/fsp_pkg.sv]
// Shared types, character codes and a helper function of the FASTA stream parser.
package fsp_pkg;

  // Character codes
  localparam logic [7:0] CharGt      = 8'h3E;  // '>'
  localparam logic [7:0] CharNl      = 8'h0A;  // '\n'
  localparam logic [7:0] CharUpperN  = 8'h4E;  // 'N'
  localparam logic [7:0] CharLowerN  = 8'h6E;  // 'n'
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharCr      = 8'h0D;
  localparam logic [7:0] CharLowerA  = 8'h61;
  localparam logic [7:0] CharLowerZ  = 8'h7A;
  localparam logic [7:0] CaseOffset  = 8'h20;
  localparam logic [7:0] CharNul     = 8'h00;

  localparam int unsigned CountW = 32;

  // Parser mode
  typedef enum logic [1:0] {
    MODE_SEQ  = 2'd0,
    MODE_NAME = 2'd1,
    MODE_HEAD = 2'd2
  } mode_e;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_NAME_CHAR = 3'd0,
    KIND_NAME_END  = 3'd1,
    KIND_NUC       = 3'd2,
    KIND_REC_END   = 3'd3,
    KIND_BAD       = 3'd4,
    KIND_UNTERM    = 3'd5
  } kind_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         out_char;
    logic [CountW-1:0]  record_number;
    logic [CountW-1:0]  line_index;
    logic [CountW-1:0]  column_index;
  } out_item_t;

  // Byte classification handed from the decoder to the control logic
  typedef struct packed {
    logic       is_nl;
    logic       is_gt;
    logic       is_space;
    logic       is_plain;
    logic       is_ambig;
    logic [7:0] norm_char;
  } class_t;

  // Counter step that holds at all ones
  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == {CountW{1'b1}}) ? v : v + {{(CountW-1){1'b0}}, 1'b1};
  endfunction

endpackage

[rtl/fsp_stream_if.sv]
// Valid/ready channels for text requests in and parse results out.
interface fsp_in_if;
  logic              valid;
  logic              ready;
  fsp_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface fsp_out_if;
  logic               valid;
  logic               ready;
  fsp_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/fsp_classify.sv]
// Byte decoder: newline, marker, whitespace, base and ambiguity-code detection.
module fsp_classify (
  input  logic [7:0]      text_byte_i,
  output fsp_pkg::class_t class_o
);

  logic [7:0] upper;

  // Fold lower case letters onto upper case
  assign upper = ((text_byte_i >= fsp_pkg::CharLowerA) && (text_byte_i <= fsp_pkg::CharLowerZ))
               ? text_byte_i - fsp_pkg::CaseOffset : text_byte_i;

  always_comb begin
    class_o.is_nl    = (text_byte_i == fsp_pkg::CharNl);
    class_o.is_gt    = (text_byte_i == fsp_pkg::CharGt);
    class_o.is_space = (text_byte_i == fsp_pkg::CharSpace) ||
                       ((text_byte_i >= fsp_pkg::CharTab) && (text_byte_i <= fsp_pkg::CharCr));
    class_o.is_plain = (upper == 8'h41) || (upper == 8'h43) || (upper == 8'h47) ||
                       (upper == 8'h54) || (upper == fsp_pkg::CharUpperN);
    // R Y S W K M B D H V
    class_o.is_ambig = (upper == 8'h52) || (upper == 8'h59) || (upper == 8'h53) ||
                       (upper == 8'h57) || (upper == 8'h4B) || (upper == 8'h4D) ||
                       (upper == 8'h42) || (upper == 8'h44) || (upper == 8'h48) ||
                       (upper == 8'h56);
    // Plain bases pass; ambiguity codes become N, keeping case
    if (class_o.is_plain) begin
      class_o.norm_char = text_byte_i;
    end else if (text_byte_i >= fsp_pkg::CharLowerA) begin
      class_o.norm_char = fsp_pkg::CharLowerN;
    end else begin
      class_o.norm_char = fsp_pkg::CharUpperN;
    end
  end

endmodule

[rtl/fsp_ctrl.sv]
// Parser state, position counters and result selection for one request.
module fsp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  fsp_pkg::in_item_t   item_i,
  input  fsp_pkg::class_t     class_i,
  output logic                res_valid_o,
  output fsp_pkg::out_item_t  result_o
);

  fsp_pkg::mode_e                 mode_q, mode_d;
  logic                           at_line_start_q, at_line_start_d;
  logic                           on_first_line_q, on_first_line_d;
  logic                           halted_q, halted_d;
  logic [fsp_pkg::CountW-1:0]     line_count_q, line_count_d;
  logic [fsp_pkg::CountW-1:0]     column_count_q, column_count_d;
  logic [fsp_pkg::CountW-1:0]     record_count_q, record_count_d;
  logic                           live;

  assign live = accept_i && !halted_q;

  // Next state
  always_comb begin
    mode_d          = mode_q;
    at_line_start_d = at_line_start_q;
    on_first_line_d = on_first_line_q;
    halted_d        = halted_q;
    line_count_d    = line_count_q;
    column_count_d  = column_count_q;
    record_count_d  = record_count_q;
    if (live) begin
      if (item_i.end_of_text) begin
        halted_d = 1'b1;
      end else if (class_i.is_nl) begin
        line_count_d    = fsp_pkg::sat_inc(line_count_q);
        column_count_d  = '0;
        mode_d          = fsp_pkg::MODE_SEQ;
        at_line_start_d = 1'b1;
        on_first_line_d = 1'b0;
      end else begin
        column_count_d = fsp_pkg::sat_inc(column_count_q);
        if (class_i.is_gt) begin
          if (!at_line_start_q) begin
            halted_d = 1'b1;
          end else begin
            at_line_start_d = 1'b0;
            mode_d          = fsp_pkg::MODE_NAME;
            if (on_first_line_q) begin
              on_first_line_d = 1'b0;
            end else begin
              record_count_d = fsp_pkg::sat_inc(record_count_q);
            end
          end
        end else begin
          at_line_start_d = 1'b0;
          case (mode_q)
            fsp_pkg::MODE_NAME: begin
              if (class_i.is_space) mode_d = fsp_pkg::MODE_HEAD;
            end
            fsp_pkg::MODE_SEQ: begin
              if (!class_i.is_plain && !class_i.is_ambig) halted_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Result selection; positions include the current byte
  always_comb begin
    res_valid_o            = 1'b0;
    result_o.kind          = fsp_pkg::KIND_NAME_CHAR;
    result_o.out_char      = fsp_pkg::CharNul;
    result_o.record_number = record_count_q;
    result_o.line_index    = line_count_d;
    result_o.column_index  = column_count_d;
    if (live) begin
      if (item_i.end_of_text) begin
        res_valid_o   = 1'b1;
        result_o.kind = (mode_q != fsp_pkg::MODE_SEQ) ? fsp_pkg::KIND_UNTERM
                                                      : fsp_pkg::KIND_REC_END;
      end else if (class_i.is_nl) begin
        if (mode_q != fsp_pkg::MODE_SEQ) begin
          res_valid_o   = 1'b1;
          result_o.kind = fsp_pkg::KIND_NAME_END;
        end
      end else if (class_i.is_gt) begin
        if (!at_line_start_q) begin
          res_valid_o       = 1'b1;
          result_o.kind     = fsp_pkg::KIND_BAD;
          result_o.out_char = item_i.text_byte;
        end else if (!on_first_line_q) begin
          res_valid_o   = 1'b1;
          result_o.kind = fsp_pkg::KIND_REC_END;
        end
      end else begin
        case (mode_q)
          fsp_pkg::MODE_NAME: begin
            if (!class_i.is_space) begin
              res_valid_o       = 1'b1;
              result_o.kind     = fsp_pkg::KIND_NAME_CHAR;
              result_o.out_char = item_i.text_byte;
            end
          end
          fsp_pkg::MODE_SEQ: begin
            res_valid_o = 1'b1;
            if (class_i.is_plain || class_i.is_ambig) begin
              result_o.kind     = fsp_pkg::KIND_NUC;
              result_o.out_char = class_i.norm_char;
            end else begin
              result_o.kind     = fsp_pkg::KIND_BAD;
              result_o.out_char = item_i.text_byte;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= fsp_pkg::MODE_SEQ;
      at_line_start_q <= 1'b1;
      on_first_line_q <= 1'b1;
      halted_q        <= 1'b0;
      line_count_q    <= '0;
      column_count_q  <= '0;
      record_count_q  <= {{(fsp_pkg::CountW-1){1'b0}}, 1'b1};
    end else begin
      mode_q          <= mode_d;
      at_line_start_q <= at_line_start_d;
      on_first_line_q <= on_first_line_d;
      halted_q        <= halted_d;
      line_count_q    <= line_count_d;
      column_count_q  <= column_count_d;
      record_count_q  <= record_count_d;
    end
  end

`ifndef NO_ASSERTIONS
  // Once halted, nothing more comes out
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted_q |-> !res_valid_o)
    else $error("fsp_ctrl: result produced while halted");

  // A fresh line has no columns counted yet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   at_line_start_q |-> (column_count_q == '0))
    else $error("fsp_ctrl: nonzero column at line start");

  // A header can only be open after the first marker was consumed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (mode_q != fsp_pkg::MODE_SEQ) |-> !on_first_line_q)
    else $error("fsp_ctrl: header mode while first-line flag set");
`endif

endmodule

[rtl/fasta_stream_parser_unit.sv]
// Top level of the FASTA stream parser: decoder, control and result register.
//
// Usage:
//   in_i carries one text byte per request (text_byte, end_of_text). A request
//   with end_of_text set closes the text and yields a record end or an
//   unterminated header error.
//   out_o carries at most one result per request: name characters, name end,
//   normalized nucleotides, record ends and errors, each tagged with record
//   number, line index and column index (counters saturate at all ones).
// Results are registered: a result appears on out_o in the cycle after its request is accepted.
// Throughput: one byte per cycle while out_o does not stall; decode and counter updates are a single
//   combinational stage feeding the one-entry result register.
// Stalls: in_i.ready is high whenever the result register is empty or is being
//   drained in the same cycle, so a stalled receiver backs up the input after
//   one pending result.
// Reset: parser returns to sequence mode at line start, record number 1,
//   counters zero, error flag clear, result register empty. After an error or
//   end of text, requests are still accepted but produce no results until reset.
module fasta_stream_parser_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  fsp_in_if.sink          in_i,
  fsp_out_if.source       out_o
);

  fsp_pkg::class_t     byte_class;
  fsp_pkg::out_item_t  result;
  fsp_pkg::out_item_t  out_item_q;
  logic                res_valid;
  logic                accept;
  logic                out_valid_q, out_valid_d;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  fsp_classify u_classify (
    .text_byte_i (in_i.payload.text_byte),
    .class_o     (byte_class)
  );

  fsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_i.payload),
    .class_i     (byte_class),
    .res_valid_o (res_valid),
    .result_o    (result)
  );

  // Result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

`ifndef NO_ASSERTIONS
  // Every produced result lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (accept && res_valid) |=> out_valid_q)
    else $error("fsp_top: produced result was dropped");

  // Only defined kinds leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q |-> (out_item_q.kind <= fsp_pkg::KIND_UNTERM))
    else $error("fsp_top: undefined result kind");

  // Kinds without a character carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && (out_item_q.kind == fsp_pkg::KIND_NAME_END ||
                                    out_item_q.kind == fsp_pkg::KIND_REC_END ||
                                    out_item_q.kind == fsp_pkg::KIND_UNTERM))
                   |-> (out_item_q.out_char == fsp_pkg::CharNul))
    else $error("fsp_top: nonzero character on a marker result");
`endif

endmodule
